FILE: src/crcd_pkg.sv
// ----------------------------------------------------------------------------
// crcd_pkg
// Shared types and constants of the clock replacement cache directory:
// default sizes, result field widths, access opcodes and controller states.
// ----------------------------------------------------------------------------
package crcd_pkg;

	// default configuration
	localparam int WAYS_DEF        = 8;
	localparam int OFFSET_BITS_DEF = 4;
	localparam int ADDR_BITS_DEF   = 32;

	// fixed field widths of the transactions
	localparam int ADDRESS_W = 32;
	localparam int WAY_W     = 3;
	localparam int VICTIM_W  = 28;
	localparam int COUNT_W   = 32;

	// access kind
	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWEEP,
		ST_FILL
	} state_t;

endpackage

FILE: src/crcd_req_if.sv
// ----------------------------------------------------------------------------
// crcd_req_if
// Access request channel: valid/ready handshake with opcode and byte address.
// ----------------------------------------------------------------------------
interface crcd_req_if
	import crcd_pkg::*;
();
	logic                 valid;
	logic                 ready;
	opcode_t              opcode;
	logic [ADDRESS_W-1:0] address;

	modport source (output valid, output opcode, output address, input ready);
	modport sink   (input valid, input opcode, input address, output ready);
endinterface

FILE: src/crcd_rsp_if.sv
// ----------------------------------------------------------------------------
// crcd_rsp_if
// Lookup result channel: valid/ready handshake with hit, way, writeback
// information and the running hit and miss counts.
// ----------------------------------------------------------------------------
interface crcd_rsp_if
	import crcd_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                hit;
	logic [WAY_W-1:0]    way;
	logic                writeback_needed;
	logic [VICTIM_W-1:0] victim_line;
	logic [COUNT_W-1:0]  hit_total;
	logic [COUNT_W-1:0]  miss_total;

	modport source (
		output valid, output hit, output way, output writeback_needed,
		output victim_line, output hit_total, output miss_total, input ready
	);
	modport sink (
		input valid, input hit, input way, input writeback_needed,
		input victim_line, input hit_total, input miss_total, output ready
	);
endinterface

FILE: src/crcd_ram.sv
// ----------------------------------------------------------------------------
// crcd_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module crcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: src/clock_replacement_cache_directory_core.sv
// ----------------------------------------------------------------------------
// clock_replacement_cache_directory_core
// Tag directory of a fully associative cache with clock (second chance)
// replacement. Line addresses live in a synchronous RAM that is scanned one
// entry per cycle; valid, dirty and reference bits and the hand are flops.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    opcode, address
//   rsp      out  valid / ready    hit, way, writeback_needed, victim_line,
//                                  hit_total, miss_total
//
// A hit on entry k gives its result once the scan reads entry k; a miss scans
// every entry, then the hand clears set reference bits up to a clear one, and
// that entry is refilled. The tag RAM read port, one entry per cycle, sets the pace.
// The controller returns to idle after each result before taking the next request.
// After reset the directory is empty and takes a request at once.
// A new request is taken once the previous result sits in the output
// register; a stalled output only holds the controller when a result is due.
// ----------------------------------------------------------------------------
module clock_replacement_cache_directory_core
	import crcd_pkg::*;
#(
	parameter int WAYS        = WAYS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	crcd_req_if.sink          req,
	crcd_rsp_if.source        rsp
);

	localparam int IDX_W  = $clog2(WAYS);
	localparam int LINE_W = ADDR_BITS - OFFSET_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WAYS - 1);

	// successor of an entry index, wrapping at WAYS
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : IDX_W'(i + 1'b1);
	endfunction

	state_t              state_q, state_d;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    hand_q;
	logic [LINE_W-1:0]   line_q;
	logic                write_q;
	logic [WAYS-1:0]     valid_q;
	logic [WAYS-1:0]     dirty_q;
	logic [WAYS-1:0]     ref_q;
	logic [COUNT_W-1:0]  hit_cnt_q;
	logic [COUNT_W-1:0]  miss_cnt_q;
	logic                out_valid_q;

	logic [IDX_W-1:0]    rd_addr;
	logic [LINE_W-1:0]   rd_data;
	logic [LINE_W-1:0]   line_in;
	logic [63:0]         addr_ext;
	logic                match;
	logic                out_free;
	logic                do_hit;
	logic                do_fill;

	// line address of the incoming request
	assign addr_ext = 64'(req.address) & ((64'd1 << ADDR_BITS) - 64'd1);
	assign line_in  = LINE_W'(addr_ext >> OFFSET_BITS);

	assign match    = valid_q[idx_q] && (rd_data == line_q);
	assign out_free = !out_valid_q || rsp.ready;

	// line address store
	crcd_ram #(
		.WIDTH (LINE_W),
		.DEPTH (WAYS)
	) u_line_ram (
		.clk   (clk),
		.we    (do_fill),
		.waddr (hand_q),
		.wdata (line_q),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, read address and commit strobes
	always_comb begin
		state_d   = state_q;
		rd_addr   = idx_q;
		do_hit    = 1'b0;
		do_fill   = 1'b0;
		req.ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = '0;
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr = next_idx(idx_q);
				if (match) begin
					if (out_free) begin
						do_hit  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						rd_addr = idx_q;
					end
				end else if (idx_q == LAST_IDX) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				rd_addr = hand_q;
				if (!ref_q[hand_q]) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				rd_addr = hand_q;
				if (out_free) begin
					do_fill = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// directory control state, hand and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			hand_q      <= '0;
			valid_q     <= '0;
			dirty_q     <= '0;
			ref_q       <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// scan index
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if (state_q == ST_SCAN && !match) begin
				idx_q <= next_idx(idx_q);
			end
			// second chance sweep
			if (state_q == ST_SWEEP && ref_q[hand_q]) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= next_idx(hand_q);
			end
			// hit update
			if (do_hit) begin
				ref_q[idx_q] <= 1'b1;
				if (write_q) begin
					dirty_q[idx_q] <= 1'b1;
				end
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
			// refill of the victim entry
			if (do_fill) begin
				valid_q[hand_q] <= 1'b1;
				dirty_q[hand_q] <= write_q;
				ref_q[hand_q]   <= 1'b0;
				hand_q          <= next_idx(hand_q);
				miss_cnt_q      <= miss_cnt_q + 1'b1;
			end
			// output register occupancy
			if (do_hit || do_fill) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			line_q  <= line_in;
			write_q <= (req.opcode == OP_WRITE);
		end
		if (do_hit) begin
			rsp.hit              <= 1'b1;
			rsp.way              <= WAY_W'(idx_q);
			rsp.writeback_needed <= 1'b0;
			rsp.victim_line      <= '0;
			rsp.hit_total        <= hit_cnt_q + 1'b1;
			rsp.miss_total       <= miss_cnt_q;
		end else if (do_fill) begin
			rsp.hit              <= 1'b0;
			rsp.way              <= WAY_W'(hand_q);
			rsp.writeback_needed <= valid_q[hand_q] && dirty_q[hand_q];
			rsp.victim_line      <= (valid_q[hand_q] && dirty_q[hand_q]) ?
			                        VICTIM_W'(rd_data) : '0;
			rsp.hit_total        <= hit_cnt_q;
			rsp.miss_total       <= miss_cnt_q + 1'b1;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for clock_replacement_cache_directory_core. Accesses go
// in on the request channel; at each accepted transaction a shadow directory
// with its own clock hand works out the expected result, which is checked
// field by field against the response channel. Directed fills, hits and
// evictions come first, then random accesses over small working sets of lines,
// with random gaps on both sides and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import crcd_pkg::*;

	localparam int WAYS         = WAYS_DEF;
	localparam int OFFSET_BITS  = OFFSET_BITS_DEF;
	localparam int ADDR_BITS    = ADDR_BITS_DEF;
	localparam int LINE_W       = ADDR_BITS - OFFSET_BITS;
	localparam int POOL_MAX     = 16;
	localparam int DRAIN_CYCLES = 3 * WAYS + 10;
	localparam int CYCLE_LIMIT  = 1_000_000;

	typedef struct packed {
		logic                hit;
		logic [WAY_W-1:0]    way;
		logic                writeback_needed;
		logic [VICTIM_W-1:0] victim_line;
		logic [COUNT_W-1:0]  hit_total;
		logic [COUNT_W-1:0]  miss_total;
	} lookup_result_t;

	logic clk;
	logic arst_n;

	crcd_req_if req_ch ();
	crcd_rsp_if rsp_ch ();

	clock_replacement_cache_directory_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow directory
	logic              dir_valid [WAYS];
	logic              dir_dirty [WAYS];
	logic              dir_ref   [WAYS];
	logic [LINE_W-1:0] dir_line  [WAYS];
	int                dir_hand;
	logic [COUNT_W-1:0] dir_hits;
	logic [COUNT_W-1:0] dir_misses;

	lookup_result_t pending_lookups [$];

	// working set of lines for random accesses
	logic [LINE_W-1:0] line_pool [POOL_MAX];
	int                pool_size;

	// flow control knobs
	bit req_steady;
	bit rsp_steady;
	int hold_left;
	int stall_left;

	// bookkeeping
	int cycle_count;
	int error_count;
	int sent_count;
	int checked_count;
	int seen_hits;
	int seen_misses;
	int seen_writebacks;
	int full_sweeps;

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// gap length, mostly short and now and then long
	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
	endfunction

	// expected result of one access, updates the shadow directory
	function automatic lookup_result_t predict_lookup(opcode_t op, logic [ADDRESS_W-1:0] addr);
		lookup_result_t    res;
		logic [LINE_W-1:0] ln;
		bit                found;
		bit                stop;
		int                slot;
		int                steps;
		res   = '0;
		ln    = addr[ADDR_BITS-1:OFFSET_BITS];
		found = 1'b0;
		stop  = 1'b0;
		slot  = 0;
		steps = 0;
		// lowest matching entry wins
		for (int i = 0; i < WAYS; i++) begin
			if (!found && dir_valid[i] && dir_line[i] == ln) begin
				found = 1'b1;
				slot  = i;
			end
		end
		if (found) begin
			dir_hits      = dir_hits + 1;
			dir_ref[slot] = 1'b1;
			if (op == OP_WRITE) begin
				dir_dirty[slot] = 1'b1;
			end
		end else begin
			dir_misses = dir_misses + 1;
			// second chance sweep
			for (int s = 0; s < WAYS; s++) begin
				if (!stop && dir_ref[dir_hand]) begin
					dir_ref[dir_hand] = 1'b0;
					dir_hand          = (dir_hand + 1) % WAYS;
					steps++;
				end else begin
					stop = 1'b1;
				end
			end
			if (steps == WAYS) begin
				full_sweeps++;
			end
			slot = dir_hand;
			if (dir_valid[slot] && dir_dirty[slot]) begin
				res.writeback_needed = 1'b1;
				res.victim_line      = dir_line[slot];
			end
			dir_valid[slot] = 1'b1;
			dir_dirty[slot] = (op == OP_WRITE);
			dir_line[slot]  = ln;
			dir_ref[slot]   = 1'b0;
			dir_hand        = (slot + 1) % WAYS;
		end
		res.hit        = found;
		res.way        = slot[WAY_W-1:0];
		res.hit_total  = dir_hits;
		res.miss_total = dir_misses;
		return res;
	endfunction

	// one request transaction, predicted when it is taken
	task automatic issue_access(input opcode_t op, input logic [ADDRESS_W-1:0] addr);
		int gap;
		gap = (req_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.opcode  <= op;
		req_ch.address <= addr;
		do @(posedge clk); while (!req_ch.ready);
		pending_lookups.push_back(predict_lookup(op, addr));
		sent_count++;
	endtask

	// sender goes quiet until every result is in
	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
	endtask

	// new random line in the working set
	function automatic void refresh_pool_entry(int k);
		line_pool[k] = LINE_W'({$urandom, $urandom});
	endfunction

	// address from the working set, sometimes anywhere
	function automatic logic [ADDRESS_W-1:0] pick_address();
		logic [ADDRESS_W-1:0] addr;
		if ($urandom_range(0, 9) == 0) begin
			addr = $urandom;
		end else begin
			addr = {line_pool[$urandom_range(0, pool_size - 1)],
				OFFSET_BITS'($urandom)};
		end
		return addr;
	endfunction

	// burst of random accesses over a working set of the given size
	task automatic run_random(input int count, input int set_size);
		pool_size = set_size;
		for (int k = 0; k < POOL_MAX; k++) begin
			refresh_pool_entry(k);
		end
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 39) == 0) begin
				refresh_pool_entry($urandom_range(0, pool_size - 1));
			end
			issue_access(opcode_t'($urandom_range(0, 1)), pick_address());
		end
	endtask

	// field compare
	task automatic check_field(input string name, input logic [31:0] expv,
			input logic [31:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
			error_count++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual hit=%0b way=%0d",
					$time, rsp_ch.hit, rsp_ch.way);
				error_count++;
			end else begin
				want = pending_lookups.pop_front();
				check_field("hit", want.hit, rsp_ch.hit);
				check_field("way", want.way, rsp_ch.way);
				check_field("writeback_needed", want.writeback_needed,
					rsp_ch.writeback_needed);
				check_field("victim_line", want.victim_line, rsp_ch.victim_line);
				check_field("hit_total", want.hit_total, rsp_ch.hit_total);
				check_field("miss_total", want.miss_total, rsp_ch.miss_total);
				checked_count++;
				if (want.hit) begin
					seen_hits++;
				end else begin
					seen_misses++;
				end
				if (want.writeback_needed) begin
					seen_writebacks++;
				end
			end
		end
	end

	// response ready with random stalls and a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!rsp_steady && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("** clock_replacement_cache_directory_core: FAILED **");
			$finish;
		end
	end

	// fills, hits, write hit, full sweep, dirty and clean evictions
	task automatic test_directed();
		issue_access(OP_READ,  32'h0000_0000);
		issue_access(OP_READ,  32'h0000_000F);
		issue_access(OP_WRITE, 32'hFFFF_FFFF);
		issue_access(OP_READ,  32'hFFFF_FFF0);
		issue_access(OP_WRITE, 32'h0000_0005);
		for (int k = 1; k <= 6; k++) begin
			issue_access(OP_READ, ADDRESS_W'(k) << 8);
		end
		// every reference bit set, so the next miss sweeps all the way round
		for (int k = 1; k <= 6; k++) begin
			issue_access(OP_READ, (ADDRESS_W'(k) << 8) | 32'hC);
		end
		issue_access(OP_READ,  32'h1234_5670);
		issue_access(OP_READ,  32'h8000_0008);
		issue_access(OP_WRITE, 32'h7FFF_FFF3);
		issue_access(OP_WRITE, 32'h7FFF_FFF3);
		wait_drained();
	endtask

	// random traffic with idling on both sides
	task automatic test_random_locality();
		run_random(500, 10);
		wait_drained();
		run_random(400, 7);
		wait_drained();
	endtask

	// back to back with no idling at all
	task automatic test_streaming();
		req_steady = 1'b1;
		rsp_steady = 1'b1;
		run_random(350, 9);
		wait_drained();
		req_steady = 1'b0;
		rsp_steady = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_backpressure();
		req_steady = 1'b1;
		hold_left  = 300;
		run_random(60, 12);
		req_steady = 1'b0;
		wait_drained();
	endtask

	// scattered addresses over a working set larger than the directory, then one that fits
	task automatic test_scattered();
		run_random(300, POOL_MAX);
		wait_drained();
		run_random(240, 5);
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.opcode  = OP_READ;
		req_ch.address = '0;
		req_steady     = 1'b0;
		rsp_steady     = 1'b0;
		hold_left      = 0;
		stall_left     = 0;
		pool_size      = 1;
		for (int i = 0; i < WAYS; i++) begin
			dir_valid[i] = 1'b0;
			dir_dirty[i] = 1'b0;
			dir_ref[i]   = 1'b0;
			dir_line[i]  = '0;
		end
		dir_hand   = 0;
		dir_hits   = '0;
		dir_misses = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_locality();
		test_streaming();
		test_output_backpressure();
		test_scattered();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_lookups.size() != 0) begin
			$display("%0t: %0d results missing, expected %0d more, actual 0",
				$time, pending_lookups.size(), pending_lookups.size());
			error_count++;
		end

		$display("run: %0d accesses, %0d results checked, %0d errors",
			sent_count, checked_count, error_count);
		$display("mix: %0d hits, %0d misses, %0d dirty evictions, %0d full sweeps",
			seen_hits, seen_misses, seen_writebacks, full_sweeps);
		if (error_count == 0) begin
			$display("** clock_replacement_cache_directory_core: PASSED **");
		end else begin
			$display("** clock_replacement_cache_directory_core: FAILED **");
		end
		$finish;
	end

endmodule

FILE: files.f
src/crcd_pkg.sv
src/crcd_req_if.sv
src/crcd_rsp_if.sv
src/crcd_ram.sv
src/clock_replacement_cache_directory_core.sv
tb/testbench.sv
